// ===== hw/rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine: command,
// draw and register codes, control characters, field widths, reset values.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int CUR_W   = 16;
    localparam int GLYPH_W = 7;
    localparam int SCR_W   = 14;
    localparam int COLOR_W = 32;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 88;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETXY = 2'd2;

    // Draw operations
    localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
    localparam logic [OP_W-1:0] OP_GLYPH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_HT = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS = 8'h08;

    // Tab advance is four cells, a shift by two
    localparam int TAB_SHIFT = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK     = 3'd5;

    // Register reset values
    localparam logic [GLYPH_W-1:0] RST_GLYPH_W  = 7'd8;
    localparam logic [GLYPH_W-1:0] RST_GLYPH_H  = 7'd16;
    localparam logic [SCR_W-1:0]   RST_SCREEN_W = 14'd1024;
    localparam logic [SCR_W-1:0]   RST_SCREEN_H = 14'd768;
    localparam logic [COLOR_W-1:0] RST_FORE     = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_BACK     = 32'h0000_0000;

    // Divider: one quotient bit per step over the screen width
    localparam int DIV_STEPS = SCR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_DIV,
        ST_BSFIN
    } state_t;

    // Saturate a 17-bit sum to the 16-bit cursor range
    function automatic logic [CUR_W-1:0] sat16(input logic [CUR_W:0] v);
        sat16 = v[CUR_W] ? {CUR_W{1'b1}} : v[CUR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/text_console_cursor_engine_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Pixel cursor for a glyph text console; turns console commands into draw
// commands (cell fill, glyph, canvas clear).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one console command per item (cmd in tuser). m_axis carries
//   draw commands; tlast marks the final draw command of one input item.
//   The cfg port writes cell size, screen size and colors; the user must write
//   them only while idle; the block itself does not enforce it.
//   Set cursor, newline, return, tab and dropped characters give no draw command.
//   A clear or backspace without wrap gives one result loaded at accept.
//   A printable character gives a fill at accept and a glyph once the fill
//   is taken; no new item is accepted until the glyph is loaded.
//   A backspace that wraps to the previous line runs a restoring divider of
//   screen width by glyph width, one quotient bit per cycle: 14 steps, then
//   a finish state loads the fill; a screen under one cell skips the divider.
// Reset: cursor goes to 0,0 and the config registers take their reset values.
// Stall: a result waits in the output register; an idle block accepts a new
//   item in the same cycle the result is taken, or while the register is free.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port
    input  logic                               cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: char_code[7:0], new_x[23:8], new_y[39:24]
    input  logic [tcce_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [tcce_pkg::CMD_W-1:0]         s_axis_tuser,

    // Draw stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pos_x[15:0], pos_y[31:16], rect_width[38:32], rect_height[45:39],
    //        color[77:46], glyph_code[85:78], zero pad[87:86]
    output logic [tcce_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // tuser: draw_op[1:0]
    output logic [tcce_pkg::OP_W-1:0]          m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int CUR_W   = tcce_pkg::CUR_W;
    localparam int GLYPH_W = tcce_pkg::GLYPH_W;
    localparam int SCR_W   = tcce_pkg::SCR_W;
    localparam int COLOR_W = tcce_pkg::COLOR_W;
    localparam int CHAR_W  = tcce_pkg::CHAR_W;
    localparam int OP_W    = tcce_pkg::OP_W;
    localparam int CNT_W   = tcce_pkg::DIV_CNT_W;
    localparam int REM_W   = GLYPH_W + 1;

    // Configuration registers
    logic [GLYPH_W-1:0] glyph_w_reg;
    logic [GLYPH_W-1:0] glyph_h_reg;
    logic [SCR_W-1:0]   screen_w_reg;
    logic [SCR_W-1:0]   screen_h_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;

    // Control state
    tcce_pkg::state_t   state_reg, state_next;
    logic [CUR_W-1:0]   cursor_x_reg, cursor_x_next;
    logic [CUR_W-1:0]   cursor_y_reg, cursor_y_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Datapath state
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [SCR_W-1:0]   dividend_reg, dividend_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    // Output register
    logic [OP_W-1:0]    op_reg, op_next;
    logic [CUR_W-1:0]   pos_x_reg, pos_x_next;
    logic [CUR_W-1:0]   pos_y_reg, pos_y_next;
    logic [GLYPH_W-1:0] rw_reg, rw_next;
    logic [GLYPH_W-1:0] rh_reg, rh_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [CHAR_W-1:0]  gcode_reg, gcode_next;
    logic               last_reg, last_next;

    // Input unpack
    logic [tcce_pkg::CMD_W-1:0] in_cmd;
    logic [CHAR_W-1:0]          in_char;
    logic [CUR_W-1:0]           in_x;
    logic [CUR_W-1:0]           in_y;
    logic                       in_acc;
    logic                       out_free;

    assign in_cmd  = s_axis_tuser;
    assign in_char = s_axis_tdata[7:0];
    assign in_x    = s_axis_tdata[23:8];
    assign in_y    = s_axis_tdata[39:24];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == tcce_pkg::ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Output pack
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = op_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {2'b00, gcode_reg, color_reg, rh_reg, rw_reg,
                            pos_y_reg, pos_x_reg};

    // Cursor arithmetic for a printable character: wrap, then bottom test
    logic [CUR_W:0]   wrap_sum;
    logic             wrap_hit;
    logic [CUR_W-1:0] pr_x;
    logic [CUR_W-1:0] pr_y;
    logic [CUR_W:0]   bottom_sum;
    logic             pr_drop;

    assign wrap_sum   = {1'b0, cursor_x_reg} + (CUR_W+1)'(glyph_w_reg);
    assign wrap_hit   = wrap_sum >= (CUR_W+1)'(screen_w_reg);
    assign pr_x       = wrap_hit ? '0 : cursor_x_reg;
    assign pr_y       = wrap_hit ? tcce_pkg::sat16({1'b0, cursor_y_reg}
                                   + (CUR_W+1)'(glyph_h_reg)) : cursor_y_reg;
    assign bottom_sum = {1'b0, pr_y} + (CUR_W+1)'(glyph_h_reg);
    assign pr_drop    = bottom_sum >= (CUR_W+1)'(screen_h_reg);

    // Divider step: shift in one dividend bit, trial subtract
    logic [REM_W-1:0] rem_sh;
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] rem_step;

    assign rem_sh   = {rem_reg[REM_W-2:0], dividend_reg[SCR_W-1]};
    assign trial    = {1'b0, rem_sh} - (REM_W+1)'(glyph_w_reg);
    assign rem_step = trial[REM_W] ? rem_sh : trial[REM_W-1:0];

    // Column of the last whole cell: screen_w - remainder - glyph_w
    logic [SCR_W-1:0] wrap_col;
    assign wrap_col = screen_w_reg - SCR_W'(rem_reg) - SCR_W'(glyph_w_reg);

    // Backspace decisions
    logic bs_back;
    logic bs_up;
    assign bs_back = cursor_x_reg >= CUR_W'(glyph_w_reg);
    assign bs_up   = cursor_y_reg >= CUR_W'(glyph_h_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                if (in_acc && in_cmd == tcce_pkg::CMD_WRITE)
                begin
                    case (in_char)
                        tcce_pkg::CH_NL, tcce_pkg::CH_CR, tcce_pkg::CH_HT:
                            state_next = tcce_pkg::ST_IDLE;
                        tcce_pkg::CH_BS:
                        begin
                            if (!bs_back && bs_up && screen_w_reg >= SCR_W'(glyph_w_reg))
                                state_next = tcce_pkg::ST_DIV;
                        end
                        default:
                        begin
                            if (!pr_drop)
                                state_next = tcce_pkg::ST_GLYPH;
                        end
                    endcase
                end
            end
            tcce_pkg::ST_GLYPH:
            begin
                if (out_free)
                    state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_DIV:
            begin
                if (div_cnt_reg == CNT_W'(tcce_pkg::DIV_STEPS - 1))
                    state_next = tcce_pkg::ST_BSFIN;
            end
            tcce_pkg::ST_BSFIN:
            begin
                if (out_free)
                    state_next = tcce_pkg::ST_IDLE;
            end
            default:
                state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    // Outputs, cursor and datapath updates
    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        div_cnt_next   = div_cnt_reg;
        char_next      = char_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        op_next        = op_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        color_next     = color_reg;
        gcode_next     = gcode_reg;
        last_next      = last_reg;

        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_cmd)
                        tcce_pkg::CMD_CLEAR:
                        begin
                            cursor_x_next  = '0;
                            cursor_y_next  = '0;
                            out_valid_next = 1'b1;
                            op_next        = tcce_pkg::OP_CLEAR;
                            pos_x_next     = '0;
                            pos_y_next     = '0;
                            rw_next        = '0;
                            rh_next        = '0;
                            color_next     = back_reg;
                            gcode_next     = '0;
                            last_next      = 1'b1;
                        end
                        tcce_pkg::CMD_SETXY:
                        begin
                            cursor_x_next = in_x;
                            cursor_y_next = in_y;
                        end
                        tcce_pkg::CMD_WRITE:
                        begin
                            case (in_char)
                                tcce_pkg::CH_NL:
                                begin
                                    cursor_x_next = '0;
                                    cursor_y_next = tcce_pkg::sat16({1'b0, cursor_y_reg}
                                                    + (CUR_W+1)'(glyph_h_reg));
                                end
                                tcce_pkg::CH_CR:
                                    cursor_x_next = '0;
                                tcce_pkg::CH_HT:
                                    cursor_x_next = tcce_pkg::sat16({1'b0, cursor_x_reg}
                                        + ((CUR_W+1)'(glyph_w_reg) << tcce_pkg::TAB_SHIFT));
                                tcce_pkg::CH_BS:
                                begin
                                    // Fill fields common to both moves
                                    op_next    = tcce_pkg::OP_FILL;
                                    rw_next    = glyph_w_reg;
                                    rh_next    = glyph_h_reg;
                                    color_next = back_reg;
                                    gcode_next = '0;
                                    last_next  = 1'b1;
                                    if (bs_back)
                                    begin
                                        cursor_x_next  = cursor_x_reg - CUR_W'(glyph_w_reg);
                                        out_valid_next = 1'b1;
                                        pos_x_next     = cursor_x_reg - CUR_W'(glyph_w_reg);
                                        pos_y_next     = cursor_y_reg;
                                    end
                                    else if (bs_up)
                                    begin
                                        cursor_y_next = cursor_y_reg - CUR_W'(glyph_h_reg);
                                        if (screen_w_reg >= SCR_W'(glyph_w_reg))
                                        begin
                                            // Wrap column needs screen_w mod glyph_w
                                            dividend_next = screen_w_reg;
                                            rem_next      = '0;
                                            div_cnt_next  = '0;
                                        end
                                        else
                                        begin
                                            // Narrow screen: wrap lands on column 0
                                            cursor_x_next  = '0;
                                            out_valid_next = 1'b1;
                                            pos_x_next     = '0;
                                            pos_y_next     = cursor_y_reg
                                                             - CUR_W'(glyph_h_reg);
                                        end
                                    end
                                end
                                default:
                                begin
                                    cursor_x_next = pr_x;
                                    cursor_y_next = pr_y;
                                    if (!pr_drop)
                                    begin
                                        out_valid_next = 1'b1;
                                        op_next        = tcce_pkg::OP_FILL;
                                        pos_x_next     = pr_x;
                                        pos_y_next     = pr_y;
                                        rw_next        = glyph_w_reg;
                                        rh_next        = glyph_h_reg;
                                        color_next     = back_reg;
                                        gcode_next     = '0;
                                        last_next      = 1'b0;
                                        char_next      = in_char;
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                            // Unknown command: ignored
                        end
                    endcase
                end
            end
            tcce_pkg::ST_GLYPH:
            begin
                // Glyph follows once the fill has left the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    op_next        = tcce_pkg::OP_GLYPH;
                    pos_x_next     = cursor_x_reg;
                    pos_y_next     = cursor_y_reg;
                    rw_next        = glyph_w_reg;
                    rh_next        = glyph_h_reg;
                    color_next     = fore_reg;
                    gcode_next     = char_reg;
                    last_next      = 1'b1;
                    cursor_x_next  = tcce_pkg::sat16({1'b0, cursor_x_reg}
                                     + (CUR_W+1)'(glyph_w_reg));
                end
            end
            tcce_pkg::ST_DIV:
            begin
                rem_next      = rem_step;
                dividend_next = {dividend_reg[SCR_W-2:0], 1'b0};
                div_cnt_next  = div_cnt_reg + CNT_W'(1);
            end
            tcce_pkg::ST_BSFIN:
            begin
                if (out_free)
                begin
                    cursor_x_next  = CUR_W'(wrap_col);
                    out_valid_next = 1'b1;
                    op_next        = tcce_pkg::OP_FILL;
                    pos_x_next     = CUR_W'(wrap_col);
                    pos_y_next     = cursor_y_reg;
                    rw_next        = glyph_w_reg;
                    rh_next        = glyph_h_reg;
                    color_next     = back_reg;
                    gcode_next     = '0;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_w_reg  <= tcce_pkg::RST_GLYPH_W;
            glyph_h_reg  <= tcce_pkg::RST_GLYPH_H;
            screen_w_reg <= tcce_pkg::RST_SCREEN_W;
            screen_h_reg <= tcce_pkg::RST_SCREEN_H;
            fore_reg     <= tcce_pkg::RST_FORE;
            back_reg     <= tcce_pkg::RST_BACK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcce_pkg::REG_GLYPH_W:  glyph_w_reg  <= cfg_data[GLYPH_W-1:0];
                tcce_pkg::REG_GLYPH_H:  glyph_h_reg  <= cfg_data[GLYPH_W-1:0];
                tcce_pkg::REG_SCREEN_W: screen_w_reg <= cfg_data[SCR_W-1:0];
                tcce_pkg::REG_SCREEN_H: screen_h_reg <= cfg_data[SCR_W-1:0];
                tcce_pkg::REG_FORE:     fore_reg     <= cfg_data[COLOR_W-1:0];
                tcce_pkg::REG_BACK:     back_reg     <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcce_pkg::ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        op_reg       <= op_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        rw_reg       <= rw_next;
        rh_reg       <= rh_next;
        color_reg    <= color_next;
        gcode_reg    <= gcode_next;
        last_reg     <= last_next;
    end

`ifndef SYNTHESIS
    // The fill of a printable character waits in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcce_pkg::ST_GLYPH |-> out_valid_reg && !last_reg
            && op_reg == tcce_pkg::OP_FILL)
        else $error("glyph pending without its fill in the output register");

    // A clear homes the cursor and presents a clear result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_cmd == tcce_pkg::CMD_CLEAR |=> out_valid_reg
            && op_reg == tcce_pkg::OP_CLEAR && cursor_x_reg == '0 && cursor_y_reg == '0)
        else $error("clear did not home the cursor");

    // Divider remainder stays below the divisor once it is done
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcce_pkg::ST_BSFIN |-> rem_reg < REM_W'(glyph_w_reg))
        else $error("divider remainder not below glyph width");

    // No input is taken while the divider runs, and its step count stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcce_pkg::ST_DIV |-> !s_axis_tready
            && div_cnt_reg < CNT_W'(tcce_pkg::DIV_STEPS))
        else $error("divider step count out of range or input accepted");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_cursor_engine_core. A queue-fed driver
// sends console commands, an internal cursor model predicts the draw items,
// and a monitor compares every draw item field by field. Runs a directed
// set at reset settings, then random traffic over many register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CMD_W      = tcce_pkg::CMD_W;
    localparam int CHAR_W     = tcce_pkg::CHAR_W;
    localparam int CUR_W      = tcce_pkg::CUR_W;
    localparam int GLYPH_W    = tcce_pkg::GLYPH_W;
    localparam int SCR_W      = tcce_pkg::SCR_W;
    localparam int COLOR_W    = tcce_pkg::COLOR_W;
    localparam int OP_W       = tcce_pkg::OP_W;
    localparam int CFG_IDX_W  = tcce_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tcce_pkg::CFG_DATA_W;
    localparam int S_DATA_W   = tcce_pkg::S_DATA_W;
    localparam int M_DATA_W   = tcce_pkg::M_DATA_W;

    // Code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 8;
    localparam int SETTLE      = 24;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [CUR_W-1:0]  nx;
        logic [CUR_W-1:0]  ny;
    } console_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CUR_W-1:0]   x;
        logic [CUR_W-1:0]   y;
        logic [GLYPH_W-1:0] w;
        logic [GLYPH_W-1:0] h;
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  glyph;
        logic               last;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]    s_tuser = '0;

    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [OP_W-1:0]     m_tuser;
    logic                m_tlast;

    // Cursor model state and register copies
    logic [GLYPH_W-1:0] glyph_w;
    logic [GLYPH_W-1:0] glyph_h;
    logic [SCR_W-1:0]   screen_w;
    logic [SCR_W-1:0]   screen_h;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic [CUR_W-1:0]   cur_x;
    logic [CUR_W-1:0]   cur_y;

    console_cmd_t pending_cmds[$];
    draw_t        expected_draws[$];
    console_cmd_t drv_cmd;
    console_cmd_t seen_cmd;
    draw_t        want_draw;
    int           mismatches = 0;
    int           accepted = 0;
    int           stall_cycles = 0;
    logic         calm;

    text_console_cursor_engine_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // No idling on either side over this stretch of items
    assign calm = (accepted >= 500) && (accepted < 800);

    function automatic logic [CUR_W-1:0] clamp_cursor(input int v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic draw_t make_draw(input logic [OP_W-1:0] op, input int x, input int y,
                                        input int w, input int h,
                                        input logic [COLOR_W-1:0] color,
                                        input logic [CHAR_W-1:0] glyph, input logic last);
        draw_t d;
        d.op    = op;
        d.x     = x[15:0];
        d.y     = y[15:0];
        d.w     = w[6:0];
        d.h     = h[6:0];
        d.color = color;
        d.glyph = glyph;
        d.last  = last;
        return d;
    endfunction

    function automatic console_cmd_t mk(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                        input logic [CUR_W-1:0] nx, input logic [CUR_W-1:0] ny);
        console_cmd_t c;
        c.cmd = cmd;
        c.ch  = ch;
        c.nx  = nx;
        c.ny  = ny;
        return c;
    endfunction

    // Advance the cursor model by one console command, queue its draw items
    task automatic apply_console_cmd(input console_cmd_t c);
        int cx;
        int cy;
        int gw;
        int gh;
        int cols;
        cx = int'(cur_x);
        cy = int'(cur_y);
        gw = int'(glyph_w);
        gh = int'(glyph_h);
        case (c.cmd)
            tcce_pkg::CMD_CLEAR:
            begin
                expected_draws.push_back(make_draw(tcce_pkg::OP_CLEAR, 0, 0, 0, 0, back,
                                                   '0, 1'b1));
                cur_x = '0;
                cur_y = '0;
            end
            tcce_pkg::CMD_SETXY:
            begin
                cur_x = c.nx;
                cur_y = c.ny;
            end
            tcce_pkg::CMD_WRITE:
            begin
                case (c.ch)
                    tcce_pkg::CH_NL:
                    begin
                        cur_x = '0;
                        cur_y = clamp_cursor(cy + gh);
                    end
                    tcce_pkg::CH_CR:
                        cur_x = '0;
                    tcce_pkg::CH_HT:
                        cur_x = clamp_cursor(cx + (gw << tcce_pkg::TAB_SHIFT));
                    tcce_pkg::CH_BS:
                    begin
                        if (cx >= gw)
                        begin
                            cur_x = CUR_W'(cx - gw);
                        end
                        else if (cy >= gh)
                        begin
                            // wrap to the last whole column of the line above
                            cols  = (gw != 0) ? int'(screen_w) / gw : 0;
                            cur_y = CUR_W'(cy - gh);
                            cur_x = (cols != 0) ? clamp_cursor((cols - 1) * gw) : '0;
                        end
                        else
                        begin
                            return;
                        end
                        expected_draws.push_back(make_draw(tcce_pkg::OP_FILL, int'(cur_x),
                                                           int'(cur_y), gw, gh,
                                                           back, '0, 1'b1));
                    end
                    default:
                    begin
                        // right-edge wrap, then drop below the bottom
                        if (cx + gw >= int'(screen_w))
                        begin
                            cx = 0;
                            cy = int'(clamp_cursor(cy + gh));
                        end
                        cur_x = CUR_W'(cx);
                        cur_y = CUR_W'(cy);
                        if (cy + gh >= int'(screen_h))
                            return;
                        expected_draws.push_back(make_draw(tcce_pkg::OP_FILL, cx, cy, gw, gh,
                                                           back, '0, 1'b0));
                        expected_draws.push_back(make_draw(tcce_pkg::OP_GLYPH, cx, cy, gw, gh,
                                                           fore, c.ch, 1'b1));
                        cur_x = clamp_cursor(cx + gw);
                    end
                endcase
            end
            default:
                ;
        endcase
    endtask

    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int pick;
        c.cmd = tcce_pkg::CMD_WRITE;
        c.ch  = CHAR_W'($urandom());
        c.nx  = CUR_W'($urandom());
        c.ny  = CUR_W'($urandom());
        pick  = int'($urandom_range(99));
        if (pick < 55)
            ;
        else if (pick < 62)
            c.ch = tcce_pkg::CH_NL;
        else if (pick < 66)
            c.ch = tcce_pkg::CH_CR;
        else if (pick < 70)
            c.ch = tcce_pkg::CH_HT;
        else if (pick < 84)
            c.ch = tcce_pkg::CH_BS;
        else if (pick < 93)
        begin
            c.cmd = tcce_pkg::CMD_SETXY;
            c.nx  = CUR_W'($urandom_range(screen_w));
            c.ny  = CUR_W'($urandom_range(screen_h));
        end
        else if (pick < 95)
            c.cmd = tcce_pkg::CMD_SETXY;
        else if (pick < 98)
            c.cmd = tcce_pkg::CMD_CLEAR;
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Register write, mirrored into the model (block is idle here)
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            tcce_pkg::REG_GLYPH_W:  glyph_w  = data[GLYPH_W-1:0];
            tcce_pkg::REG_GLYPH_H:  glyph_h  = data[GLYPH_W-1:0];
            tcce_pkg::REG_SCREEN_W: screen_w = data[SCR_W-1:0];
            tcce_pkg::REG_SCREEN_H: screen_h = data[SCR_W-1:0];
            tcce_pkg::REG_FORE:     fore     = data;
            tcce_pkg::REG_BACK:     back     = data;
            default:                ;
        endcase
    endtask

    // Wait until every command is taken and every draw item has arrived
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_draws.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int gw, input int gh, input int sw, input int sh,
                             input logic [31:0] fg, input logic [31:0] bg, input int count);
        logic [31:0] junk;
        junk = $urandom_range(1) ? $urandom() : 32'h0;
        write_reg(tcce_pkg::REG_GLYPH_W, {junk[31:7], gw[6:0]});
        write_reg(tcce_pkg::REG_GLYPH_H, {junk[24:0], gh[6:0]});
        write_reg(tcce_pkg::REG_SCREEN_W, {junk[17:0], sw[13:0]});
        write_reg(tcce_pkg::REG_SCREEN_H, {junk[31:14], sh[13:0]});
        write_reg(tcce_pkg::REG_FORE, fg);
        write_reg(tcce_pkg::REG_BACK, bg);
        @(posedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < count; i++)
            pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    // Command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                drv_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drv_cmd.ny, drv_cmd.nx, drv_cmd.ch};
                s_tuser  <= drv_cmd.cmd;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Draw stream back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on accepted commands, then check accepted draw items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                seen_cmd = mk(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]);
                apply_console_cmd(seen_cmd);
                accepted <= accepted + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("unexpected draw item: op %0d tdata %0h", m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want_draw = expected_draws.pop_front();
                    check_field("draw_op", 32'(want_draw.op), 32'(m_tuser));
                    check_field("pos_x", 32'(want_draw.x), 32'(m_tdata[15:0]));
                    check_field("pos_y", 32'(want_draw.y), 32'(m_tdata[31:16]));
                    check_field("rect_width", 32'(want_draw.w), 32'(m_tdata[38:32]));
                    check_field("rect_height", 32'(want_draw.h), 32'(m_tdata[45:39]));
                    check_field("color", want_draw.color, m_tdata[77:46]);
                    check_field("glyph_code", 32'(want_draw.glyph), 32'(m_tdata[85:78]));
                    check_field("pad", 32'h0, 32'(m_tdata[87:86]));
                    check_field("last", 32'(want_draw.last), 32'(m_tlast));
                end
            end
        end
    end

    // Watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("text_console_cursor_engine_core test failed");
            $finish;
        end
    end

    initial
    begin
        glyph_w  = tcce_pkg::RST_GLYPH_W;
        glyph_h  = tcce_pkg::RST_GLYPH_H;
        screen_w = tcce_pkg::RST_SCREEN_W;
        screen_h = tcce_pkg::RST_SCREEN_H;
        fore     = tcce_pkg::RST_FORE;
        back     = tcce_pkg::RST_BACK;
        cur_x    = '0;
        cur_y    = '0;

        // Directed set at reset settings: 8x16 cells on 1024x768
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h41, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h00, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_CR, 16'h0, 16'h0));
        // backspace at home does nothing
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_NL, 16'h0, 16'h0));
        // backspace wraps to the last column of the line above
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 16'h0, 16'h0));
        // past the right edge: wraps before drawing
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h7A, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_SETXY, 8'h0, 16'd0, 16'd752));
        // bottom row is dropped
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h42, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_SETXY, 8'hFF, 16'hFFFF, 16'hFFFF));
        // saturation of both coordinates
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_NL, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h43, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_CLEAR, 8'h0, 16'h0, 16'h0));
        pending_cmds.push_back(mk(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(mk(tcce_pkg::CMD_SETXY, 8'h0, 16'd1016, 16'd0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, 8'h7E, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 16'h0, 16'h0));
        pending_cmds.push_back(mk(tcce_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Random traffic over a spread of settings
        run_phase(8, 16, 1024, 768, tcce_pkg::RST_FORE, tcce_pkg::RST_BACK, 125);
        run_phase(1, 1, 8192, 8192, 32'h0, 32'hFFFF_FFFF, 125);
        run_phase(64, 64, 8192, 8192, $urandom(), $urandom(), 125);
        run_phase(64, 64, 200, 300, 32'hFFFF_FFFF, 32'h0, 125);
        // zero-size cells
        run_phase(0, 0, 100, 100, $urandom(), $urandom(), 125);
        // screen narrower than one cell
        run_phase(40, 8, 30, 500, $urandom(), $urandom(), 125);
        run_phase(127, 127, 16383, 16383, $urandom(), $urandom(), 125);
        run_phase(1, 1, 1, 1, $urandom(), $urandom(), 125);
        run_phase(0, 127, 0, 0, $urandom(), $urandom(), 60);
        for (int p = 0; p < 2; p++)
            run_phase($urandom_range(1, 64), $urandom_range(1, 64),
                      $urandom_range(1, 3) == 1 ? $urandom_range(1, 8192) : $urandom_range(1, 600),
                      $urandom_range(1, 3) == 1 ? $urandom_range(1, 8192) : $urandom_range(1, 600),
                      $urandom(), $urandom(), 125);

        if (mismatches == 0 && expected_draws.size() == 0)
            $display("text_console_cursor_engine_core test passed");
        else
            $display("text_console_cursor_engine_core test failed");
        $finish;
    end

endmodule
